### hw/rtl/rswpo_pkg.sv
// Shared types and codes for the seat ring with priority overflow queues.
`timescale 1ns / 1ps
package rswpo_pkg;

  localparam int ID_W = 8;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_LEAVE  = 1'b1;

  typedef enum logic [2:0] {
    EV_SEATED  = 3'd0,
    EV_QUEUED  = 3'd1,
    EV_LEFT    = 3'd2,
    EV_EMPTY   = 3'd3,
    EV_DROPPED = 3'd4
  } event_t;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] customer_id;
    logic            priority_req;
  } in_item_t;

  typedef struct packed {
    event_t          event_res;
    logic [ID_W-1:0] customer_id_out;
    logic            last;
  } out_item_t;

endpackage

### hw/rtl/rswpo_ram.sv
// Simple dual-port RAM with registered, write-first read.
`timescale 1ns / 1ps
module rswpo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ring_seats_with_priority_overflow_core.sv
// Top level: seat ring with two-class overflow wait queues.
`timescale 1ns / 1ps
// An arrival is seated at the ring tail while a seat is free, otherwise it
// waits in the priority or ordinary queue, or is dropped when that queue is
// full. A leave frees the oldest seat and reports its id, or reports empty on
// an empty ring; the oldest priority waiter, else the oldest ordinary waiter,
// then takes the seat. Each item is decided in the cycle it transfers and its
// results appear from the next cycle on. Arrivals and leaves with nobody
// waiting give one result each; a leave that seats a waiter gives two results
// and holds off input until the second, kept in the two-entry result
// register, is taken. Seat and queue contents live in RAMs whose read
// port always prefetches the entry at the head pointer, so no clearing pass follows reset.
module ring_seats_with_priority_overflow_core #(
  parameter int TABLE_SEATS = 5,
  parameter int WAIT_DEPTH  = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rswpo_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rswpo_pkg::out_item_t out_data
);

  import rswpo_pkg::*;

  localparam int IdW      = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int SeatPtrW = (TABLE_SEATS > 1) ? $clog2(TABLE_SEATS) : 1;
  localparam int SeatCntW = $clog2(TABLE_SEATS + 1);
  localparam int WaitPtrW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WaitCntW = $clog2(WAIT_DEPTH + 1);

  localparam logic [SeatPtrW-1:0] SeatLast = SeatPtrW'(TABLE_SEATS - 1);
  localparam logic [SeatCntW-1:0] SeatFull = SeatCntW'(TABLE_SEATS);
  localparam logic [WaitPtrW-1:0] WaitLast = WaitPtrW'(WAIT_DEPTH - 1);
  localparam logic [WaitCntW-1:0] WaitFull = WaitCntW'(WAIT_DEPTH);

  logic [SeatPtrW-1:0] seat_head_r, seat_head_nxt, seat_tail_r, seat_tail_nxt;
  logic [SeatCntW-1:0] seat_count_r, seat_count_nxt;
  logic [WaitPtrW-1:0] vip_head_r, vip_head_nxt, vip_tail_r, vip_tail_nxt;
  logic [WaitCntW-1:0] vip_count_r, vip_count_nxt;
  logic [WaitPtrW-1:0] plain_head_r, plain_head_nxt, plain_tail_r, plain_tail_nxt;
  logic [WaitCntW-1:0] plain_count_r, plain_count_nxt;

  logic           seat_we, vip_we, plain_we;
  logic [IdW-1:0] seat_wdata, arr_id, seat_head_id, vip_head_id, plain_head_id;
  logic [IdW-1:0] promo_id;

  out_item_t out_r, pend_r, res0, res1;
  logic      out_valid_r, pend_valid_r, two_res;
  logic      in_fire, out_fire, waiter;

  assign in_stall  = pend_valid_r | (out_valid_r & out_stall);
  assign in_fire   = in_valid & ~in_stall;
  assign out_fire  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign arr_id   = in_data.customer_id[IdW-1:0];
  assign waiter   = (vip_count_r != '0) || (plain_count_r != '0);
  assign promo_id = (vip_count_r != '0) ? vip_head_id : plain_head_id;

  always_comb begin
    seat_head_nxt   = seat_head_r;
    seat_tail_nxt   = seat_tail_r;
    seat_count_nxt  = seat_count_r;
    vip_head_nxt    = vip_head_r;
    vip_tail_nxt    = vip_tail_r;
    vip_count_nxt   = vip_count_r;
    plain_head_nxt  = plain_head_r;
    plain_tail_nxt  = plain_tail_r;
    plain_count_nxt = plain_count_r;
    seat_we         = 1'b0;
    vip_we          = 1'b0;
    plain_we        = 1'b0;
    seat_wdata      = arr_id;
    two_res         = 1'b0;
    res0            = '{event_res: EV_SEATED, customer_id_out: ID_W'(arr_id), last: 1'b1};
    res1            = '{event_res: EV_SEATED, customer_id_out: ID_W'(promo_id), last: 1'b1};
    if (in_fire) begin
      if (in_data.command == CMD_ARRIVE) begin
        if (seat_count_r != SeatFull) begin
          seat_we        = 1'b1;
          seat_tail_nxt  = (seat_tail_r == SeatLast) ? '0 : seat_tail_r + 1'b1;
          seat_count_nxt = seat_count_r + 1'b1;
        end else if (in_data.priority_req) begin
          if (vip_count_r != WaitFull) begin
            vip_we          = 1'b1;
            vip_tail_nxt    = (vip_tail_r == WaitLast) ? '0 : vip_tail_r + 1'b1;
            vip_count_nxt   = vip_count_r + 1'b1;
            res0.event_res  = EV_QUEUED;
          end else begin
            res0.event_res  = EV_DROPPED;
          end
        end else begin
          if (plain_count_r != WaitFull) begin
            plain_we        = 1'b1;
            plain_tail_nxt  = (plain_tail_r == WaitLast) ? '0 : plain_tail_r + 1'b1;
            plain_count_nxt = plain_count_r + 1'b1;
            res0.event_res  = EV_QUEUED;
          end else begin
            res0.event_res  = EV_DROPPED;
          end
        end
      end else if (seat_count_r == '0) begin
        res0.event_res       = EV_EMPTY;
        res0.customer_id_out = '0;
      end else begin
        res0.event_res       = EV_LEFT;
        res0.customer_id_out = ID_W'(seat_head_id);
        res0.last            = ~waiter;
        seat_head_nxt        = (seat_head_r == SeatLast) ? '0 : seat_head_r + 1'b1;
        if (waiter) begin
          two_res       = 1'b1;
          seat_we       = 1'b1;
          seat_wdata    = promo_id;
          seat_tail_nxt = (seat_tail_r == SeatLast) ? '0 : seat_tail_r + 1'b1;
          if (vip_count_r != '0) begin
            vip_head_nxt  = (vip_head_r == WaitLast) ? '0 : vip_head_r + 1'b1;
            vip_count_nxt = vip_count_r - 1'b1;
          end else begin
            plain_head_nxt  = (plain_head_r == WaitLast) ? '0 : plain_head_r + 1'b1;
            plain_count_nxt = plain_count_r - 1'b1;
          end
        end else begin
          seat_count_nxt = seat_count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seat_head_r   <= '0;
      seat_tail_r   <= '0;
      seat_count_r  <= '0;
      vip_head_r    <= '0;
      vip_tail_r    <= '0;
      vip_count_r   <= '0;
      plain_head_r  <= '0;
      plain_tail_r  <= '0;
      plain_count_r <= '0;
      out_valid_r   <= 1'b0;
      pend_valid_r  <= 1'b0;
    end else begin
      seat_head_r   <= seat_head_nxt;
      seat_tail_r   <= seat_tail_nxt;
      seat_count_r  <= seat_count_nxt;
      vip_head_r    <= vip_head_nxt;
      vip_tail_r    <= vip_tail_nxt;
      vip_count_r   <= vip_count_nxt;
      plain_head_r  <= plain_head_nxt;
      plain_tail_r  <= plain_tail_nxt;
      plain_count_r <= plain_count_nxt;
      if (in_fire) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= two_res;
      end else if (out_fire) begin
        out_valid_r  <= pend_valid_r;
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r  <= res0;
      pend_r <= res1;
    end else if (out_fire && pend_valid_r) begin
      out_r <= pend_r;
    end
  end

  rswpo_ram #(.WIDTH(IdW), .DEPTH(TABLE_SEATS)) u_seat_ram (
    .clk   (clk),
    .we    (seat_we),
    .waddr (seat_tail_r),
    .wdata (seat_wdata),
    .raddr (seat_head_nxt),
    .rdata (seat_head_id)
  );

  rswpo_ram #(.WIDTH(IdW), .DEPTH(WAIT_DEPTH)) u_vip_ram (
    .clk   (clk),
    .we    (vip_we),
    .waddr (vip_tail_r),
    .wdata (arr_id),
    .raddr (vip_head_nxt),
    .rdata (vip_head_id)
  );

  rswpo_ram #(.WIDTH(IdW), .DEPTH(WAIT_DEPTH)) u_plain_ram (
    .clk   (clk),
    .we    (plain_we),
    .waddr (plain_tail_r),
    .wdata (arr_id),
    .raddr (plain_head_nxt),
    .rdata (plain_head_id)
  );

  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending result without current result");

  a_seat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seat_count_r <= SeatFull)
    else $error("seat count above ring size");

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vip_count_r <= WaitFull) && (plain_count_r <= WaitFull))
    else $error("wait count above queue depth");

  a_wait_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    waiter |-> (seat_count_r == SeatFull))
    else $error("waiter present while a seat is free");

  a_fire_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("transfer produced no result");

endmodule

### tb/seat_ring_checker.sv
// Checker for the seat ring: predicts results from input transfers and compares result transfers.
`timescale 1ns / 1ps
module seat_ring_checker #(
  parameter int TABLE_SEATS = 5,
  parameter int WAIT_DEPTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  rswpo_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rswpo_pkg::out_item_t out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   drops_seen,
  output int                   promotions_seen
);

  import rswpo_pkg::*;

  logic [ID_W-1:0] seated_q[$];
  logic [ID_W-1:0] vip_q[$];
  logic [ID_W-1:0] plain_q[$];
  out_item_t       expected_results[$];
  int              fails;
  int              checked;
  int              drops;
  int              promotions;

  function automatic out_item_t mk_result(input event_t ev, input logic [ID_W-1:0] id,
                                          input logic fin);
    out_item_t r;
    r.event_res       = ev;
    r.customer_id_out = id;
    r.last            = fin;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic predict_transfer(input in_item_t it);
    logic [ID_W-1:0] gone;
    logic [ID_W-1:0] nxt;
    bit              waiting;
    if (it.command == CMD_ARRIVE) begin
      if (seated_q.size() < TABLE_SEATS) begin
        seated_q.push_back(it.customer_id);
        expected_results.push_back(mk_result(EV_SEATED, it.customer_id, 1'b1));
      end else if (it.priority_req) begin
        if (vip_q.size() < WAIT_DEPTH) begin
          vip_q.push_back(it.customer_id);
          expected_results.push_back(mk_result(EV_QUEUED, it.customer_id, 1'b1));
        end else begin
          drops++;
          expected_results.push_back(mk_result(EV_DROPPED, it.customer_id, 1'b1));
        end
      end else begin
        if (plain_q.size() < WAIT_DEPTH) begin
          plain_q.push_back(it.customer_id);
          expected_results.push_back(mk_result(EV_QUEUED, it.customer_id, 1'b1));
        end else begin
          drops++;
          expected_results.push_back(mk_result(EV_DROPPED, it.customer_id, 1'b1));
        end
      end
    end else if (seated_q.size() == 0) begin
      expected_results.push_back(mk_result(EV_EMPTY, '0, 1'b1));
    end else begin
      gone    = seated_q.pop_front();
      waiting = (vip_q.size() != 0) || (plain_q.size() != 0);
      expected_results.push_back(mk_result(EV_LEFT, gone, !waiting));
      if (waiting) begin
        if (vip_q.size() != 0) nxt = vip_q.pop_front();
        else nxt = plain_q.pop_front();
        seated_q.push_back(nxt);
        promotions++;
        expected_results.push_back(mk_result(EV_SEATED, nxt, 1'b1));
      end
    end
  endtask

  task automatic check_transfer(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result event %0d id %0d last %0b",
                                got.event_res, got.customer_id_out, got.last));
    end else begin
      want = expected_results.pop_front();
      checked++;
      if (got.event_res !== want.event_res)
        report_mismatch($sformatf("event_res got %0d want %0d", got.event_res,
                                  want.event_res));
      if (got.customer_id_out !== want.customer_id_out)
        report_mismatch($sformatf("customer_id_out got %0d want %0d",
                                  got.customer_id_out, want.customer_id_out));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seated_q.delete();
      vip_q.delete();
      plain_q.delete();
      expected_results.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) check_transfer(out_data);
      if (in_valid === 1'b1 && in_stall === 1'b0) predict_transfer(in_data);
    end
    fail_count      <= fails;
    pending         <= expected_results.size();
    results_seen    <= checked;
    drops_seen      <= drops;
    promotions_seen <= promotions;
  end

endmodule

### tb/tb_ring_seats_with_priority_overflow_core.sv
// Testbench top: clock, reset, stimulus and verdict for the seat ring core.
`timescale 1ns / 1ps
module tb_ring_seats_with_priority_overflow_core;
  import rswpo_pkg::*;

  localparam int SEATS         = 5;
  localparam int WAIT_SLOTS    = 16;
  localparam int RANDOM_ITEMS  = 930;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  bit        quiet     = 1'b0;
  int        cycle_count = 0;
  int        items_sent  = 0;
  int        fail_count;
  int        pending;
  int        results_seen;
  int        drops_seen;
  int        promotions_seen;

  ring_seats_with_priority_overflow_core #(
    .TABLE_SEATS(SEATS),
    .WAIT_DEPTH (WAIT_SLOTS),
    .ID_BITS    (ID_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  seat_ring_checker #(
    .TABLE_SEATS(SEATS),
    .WAIT_DEPTH (WAIT_SLOTS)
  ) seat_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .drops_seen     (drops_seen),
    .promotions_seen(promotions_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 11);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [ID_W-1:0] id, input logic prio);
    in_item_t it;
    it.command      = cmd;
    it.customer_id  = id;
    it.priority_req = prio;
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin
    int run_len;
    int arrive_pct;
    int prio_pct;
    int sent_random;
    int directed;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // leave on an empty ring, then fill every seat with extreme ids
    send_item(CMD_LEAVE, 8'hA5, 1'b1);
    send_item(CMD_ARRIVE, 8'h00, 1'b0);
    send_item(CMD_ARRIVE, 8'hFF, 1'b1);
    send_item(CMD_ARRIVE, 8'h01, 1'b0);
    send_item(CMD_ARRIVE, 8'h02, 1'b1);
    send_item(CMD_ARRIVE, 8'h80, 1'b0);
    // ring full: ordinary and priority waiters
    send_item(CMD_ARRIVE, 8'h11, 1'b0);
    send_item(CMD_ARRIVE, 8'h22, 1'b1);
    send_item(CMD_ARRIVE, 8'h33, 1'b0);
    send_item(CMD_ARRIVE, 8'h7F, 1'b1);
    // promote priority first, then ordinary, then drain to empty
    repeat (6) send_item(CMD_LEAVE, 8'h5A, 1'b0);
    repeat (5) send_item(CMD_LEAVE, 8'hFF, 1'b1);
    directed = items_sent;

    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      run_len  = $urandom_range(20, 80);
      prio_pct = $urandom_range(0, 100);
      case ($urandom_range(0, 4))
        0, 1:    arrive_pct = 85;
        2, 3:    arrive_pct = 50;
        default: arrive_pct = 15;
      endcase
      for (int k = 0; k < run_len && sent_random < RANDOM_ITEMS; k++) begin
        quiet <= (sent_random >= 350) && (sent_random < 550);
        send_item(($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_LEAVE,
                  ID_W'($urandom_range(0, 255)), $urandom_range(0, 99) < prio_pct);
        sent_random++;
      end
    end
    in_valid <= 1'b0;
    quiet    <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d directed, %0d random), %0d results checked",
             items_sent, directed, items_sent - directed, results_seen);
    $display("waiting queues: %0d arrivals dropped, %0d waiters promoted to seats",
             drops_seen, promotions_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
